// File: design/pfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types, codes and helpers for the phasor frame serializer.
// ----------------------------------------------------------------------------
package pfs_pkg;

    // input item kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_CHANNEL = 2'd1;
    localparam logic [1:0] KIND_TAIL    = 2'd2;

    // configuration register indexes
    localparam logic REG_STATION_ID = 1'b0;
    localparam logic REG_SUM_ENABLE = 1'b1;

    localparam logic [7:0]  SYNC_HI      = 8'hAA;
    localparam logic [7:0]  SYNC_LO      = 8'h01;
    localparam int          FRAME_BASE   = 32;
    localparam logic [10:0] MS_PER_S     = 11'd1000;
    localparam logic [9:0]  US_PER_MS    = 10'd1000;
    localparam int          QUEUE_DEPTH  = 2;
    localparam int          DIV_STEPS    = 2;
    // ceil(2^38 / 1000), exact quotient for every 32-bit timestamp
    localparam logic [28:0] DIV_MAGIC    = 29'd274877907;

    // last byte index of a header, a data entry and a tail with checksum
    localparam logic [3:0] HDR_LAST_IDX  = 4'd13;
    localparam logic [3:0] DATA_LAST_IDX = 4'd7;
    localparam logic [3:0] SUM_LAST_IDX  = 4'd9;

    typedef enum logic [1:0] {
        ENT_HEADER,
        ENT_CHANNEL,
        ENT_TAIL
    } entry_op_t;

    typedef struct packed {
        entry_op_t   op;
        logic [31:0] first_word;   // seconds for a header
        logic [31:0] second_word;  // microseconds for a header
    } entry_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_DIV,
        FRONT_DONE
    } front_state_t;

    // byte k of a word, most significant first
    function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = w[31:24];
            2'd1:    b = w[23:16];
            2'd2:    b = w[15:8];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// File: design/pfs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfs_front
// Accepts items, splits header timestamps into seconds and microseconds by a
// reciprocal multiply, then a remainder, and pushes work entries into the queue.
// ----------------------------------------------------------------------------
module pfs_front
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            kind,
    input  wire logic [31:0]           time_ms,
    input  wire logic [31:0]           first_word,
    input  wire logic [31:0]           second_word,
    input  pfs_pkg::queue_status_t     queue_status,
    output logic                       push_valid,
    output pfs_pkg::entry_t            push_entry
);

    pfs_pkg::front_state_t state_reg;
    pfs_pkg::front_state_t state_next;
    logic        count_reg;
    logic [31:0] ms_reg;
    logic [9:0]  rem_reg;
    logic [22:0] quo_reg;

    logic        accept;
    logic        hdr_accept;
    logic [60:0] prod;
    logic [33:0] quo_ms;
    logic [31:0] ms_diff;
    logic [19:0] usec;

    assign accept     = in_valid && !in_stall;
    assign hdr_accept = accept && (kind == pfs_pkg::KIND_HEADER);

    // first step: quotient by reciprocal, shift by 38
    // second step: remainder from the quotient
    assign prod    = ms_reg * pfs_pkg::DIV_MAGIC;
    assign quo_ms  = quo_reg * pfs_pkg::MS_PER_S;
    assign ms_diff = ms_reg - quo_ms[31:0];
    assign usec    = rem_reg * pfs_pkg::US_PER_MS;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfs_pkg::FRONT_IDLE:
            begin
                if (hdr_accept)
                    state_next = pfs_pkg::FRONT_DIV;
            end
            pfs_pkg::FRONT_DIV:
            begin
                if (count_reg == 1'(pfs_pkg::DIV_STEPS - 1))
                    state_next = pfs_pkg::FRONT_DONE;
            end
            pfs_pkg::FRONT_DONE:
            begin
                if (!queue_status.full)
                    state_next = pfs_pkg::FRONT_IDLE;
            end
            default: state_next = pfs_pkg::FRONT_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall                = 1'b1;
        push_valid              = 1'b0;
        push_entry.op           = pfs_pkg::ENT_CHANNEL;
        push_entry.first_word   = first_word;
        push_entry.second_word  = second_word;
        case (state_reg)
            pfs_pkg::FRONT_IDLE:
            begin
                in_stall   = queue_status.full;
                push_valid = in_valid && !queue_status.full &&
                             (kind == pfs_pkg::KIND_CHANNEL || kind == pfs_pkg::KIND_TAIL);
                push_entry.op = (kind == pfs_pkg::KIND_TAIL) ? pfs_pkg::ENT_TAIL
                                                             : pfs_pkg::ENT_CHANNEL;
            end
            pfs_pkg::FRONT_DONE:
            begin
                push_valid             = !queue_status.full;
                push_entry.op          = pfs_pkg::ENT_HEADER;
                push_entry.first_word  = 32'(quo_reg);
                push_entry.second_word = 32'(usec);
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfs_pkg::FRONT_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (hdr_accept)
                count_reg <= '0;
            else if (state_reg == pfs_pkg::FRONT_DIV)
                count_reg <= count_reg + 1'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_accept)
            ms_reg <= time_ms;
        else if (state_reg == pfs_pkg::FRONT_DIV)
        begin
            if (count_reg == '0)
                quo_reg <= prod[60:38];
            else
                rem_reg <= ms_diff[9:0];
        end
    end

endmodule
`default_nettype wire

// File: design/pfs_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfs_queue
// Short first-in first-out queue of work entries between front and back.
// ----------------------------------------------------------------------------
module pfs_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    input  pfs_pkg::entry_t        push_entry,
    input  wire logic              pop,
    output pfs_pkg::queue_status_t queue_status,
    output pfs_pkg::entry_t        head
);

    localparam int PTR_W = $clog2(pfs_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(pfs_pkg::QUEUE_DEPTH + 1);

    pfs_pkg::entry_t slot_reg [pfs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign queue_status.valid = (count_reg != '0);
    assign queue_status.full  = (count_reg == CNT_W'(pfs_pkg::QUEUE_DEPTH));
    assign do_push = push_valid && !queue_status.full;
    assign do_pop  = pop && queue_status.valid;
    assign head    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(pfs_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(pfs_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule
`default_nettype wire

// File: design/pfs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfs_back
// Walks the head entry byte by byte into the output register and keeps the
// running byte sum of the frame.
// ----------------------------------------------------------------------------
module pfs_back
#(
    parameter logic [15:0] FRAME_LEN = 16'd64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  pfs_pkg::queue_status_t queue_status,
    input  pfs_pkg::entry_t        head,
    output logic                   pop,
    input  wire logic [15:0]       station_id,
    input  wire logic              sum_enable,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [7:0]             out_byte,
    output logic                   last_byte
);

    logic [3:0]  idx_reg;
    logic [3:0]  idx_next;
    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        last_byte_reg;

    logic        load;
    logic [3:0]  last_idx;
    logic [3:0]  hdr_k;
    logic [7:0]  sel_byte;
    logic        is_sum_byte;
    logic        is_last;

    assign load  = queue_status.valid && (!out_valid_reg || !out_stall);
    assign hdr_k = idx_reg + 4'd2;

    always_comb
    begin
        case (head.op)
            pfs_pkg::ENT_HEADER: last_idx = pfs_pkg::HDR_LAST_IDX;
            pfs_pkg::ENT_TAIL:   last_idx = sum_enable ? pfs_pkg::SUM_LAST_IDX
                                                       : pfs_pkg::DATA_LAST_IDX;
            default:             last_idx = pfs_pkg::DATA_LAST_IDX;
        endcase
    end

    assign is_sum_byte = (head.op == pfs_pkg::ENT_TAIL) && idx_reg[3];
    assign is_last     = (idx_reg == last_idx);

    always_comb
    begin
        if (head.op == pfs_pkg::ENT_HEADER)
        begin
            case (idx_reg)
                4'd0:    sel_byte = pfs_pkg::SYNC_HI;
                4'd1:    sel_byte = pfs_pkg::SYNC_LO;
                4'd2:    sel_byte = FRAME_LEN[15:8];
                4'd3:    sel_byte = FRAME_LEN[7:0];
                4'd4:    sel_byte = station_id[15:8];
                4'd5:    sel_byte = station_id[7:0];
                4'd6, 4'd7, 4'd8, 4'd9:
                         sel_byte = pfs_pkg::word_byte(head.first_word, hdr_k[1:0]);
                default: sel_byte = pfs_pkg::word_byte(head.second_word, hdr_k[1:0]);
            endcase
        end
        else if (is_sum_byte)
            sel_byte = idx_reg[0] ? sum_reg[7:0] : sum_reg[15:8];
        else if (idx_reg[2])
            sel_byte = pfs_pkg::word_byte(head.second_word, idx_reg[1:0]);
        else
            sel_byte = pfs_pkg::word_byte(head.first_word, idx_reg[1:0]);
    end

    always_comb
    begin
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && out_stall;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            pop            = is_last;
            idx_next       = is_last ? 4'd0 : idx_reg + 4'd1;
            // a header restarts the sum; checksum bytes stay out of it
            if (head.op == pfs_pkg::ENT_HEADER && idx_reg == 4'd0)
                sum_next = {8'd0, sel_byte};
            else if (!is_sum_byte)
                sum_next = sum_reg + {8'd0, sel_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= sel_byte;
            last_byte_reg <= is_last && (head.op == pfs_pkg::ENT_TAIL);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_byte_reg;

endmodule
`default_nettype wire

// File: design/phasor_frame_serializer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phasor_frame_serializer
// Serializes header, channel and tail items into the bytes of a phasor data
// frame, most significant byte first.
// ----------------------------------------------------------------------------
// Output runs at one byte per cycle unless stalled or the queue is empty:
// channel and tail items are 8 bytes (10 with the checksum), a header 14.
// Channel and tail items are taken one per cycle while the two-entry queue
// has room. A header holds the input side while a two-step reciprocal multiply
// splits the timestamp into seconds and microseconds, longer while the queue
// is full; the output keeps draining earlier items. The user must write
// configuration only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module phasor_frame_serializer
#(
    parameter int CHANNEL_COUNT = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [31:0] time_ms,
    input  wire logic [31:0] first_word,
    input  wire logic [31:0] second_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             last_byte
);

    localparam logic [15:0] FRAME_LEN = 16'(pfs_pkg::FRAME_BASE + 8 * CHANNEL_COUNT);

    logic [15:0] station_id_reg;
    logic        sum_enable_reg;

    pfs_pkg::queue_status_t queue_status;
    pfs_pkg::entry_t        push_entry;
    pfs_pkg::entry_t        head;
    logic                   push_valid;
    logic                   pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_id_reg <= 16'd1;
            sum_enable_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pfs_pkg::REG_STATION_ID: station_id_reg <= cfg_data;
                pfs_pkg::REG_SUM_ENABLE: sum_enable_reg <= cfg_data[0];
                default:                 station_id_reg <= station_id_reg;
            endcase
        end
    end

    pfs_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .time_ms      (time_ms),
        .first_word   (first_word),
        .second_word  (second_word),
        .queue_status (queue_status),
        .push_valid   (push_valid),
        .push_entry   (push_entry)
    );

    pfs_queue u_queue
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_valid   (push_valid),
        .push_entry   (push_entry),
        .pop          (pop),
        .queue_status (queue_status),
        .head         (head)
    );

    pfs_back #(
        .FRAME_LEN (FRAME_LEN)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_status (queue_status),
        .head         (head),
        .pop          (pop),
        .station_id   (station_id_reg),
        .sum_enable   (sum_enable_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .last_byte    (last_byte)
    );

endmodule
`default_nettype wire

// File: design/pfs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfs_checker
// Port-level checks for the phasor frame serializer, bound to the top level.
// ----------------------------------------------------------------------------
module pfs_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [1:0]  kind,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  out_byte,
    input wire logic        last_byte
);

    // a stalled output byte holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_byte))
        else $error("output byte changed while stalled");

    // timestamp split keeps the input side busy after a header transaction
    a_hdr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == pfs_pkg::KIND_HEADER |=> in_stall ##1 in_stall)
        else $error("input taken while timestamp divider busy");

    // input stall only rises right after an input transaction
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
        else $error("input stall rose without a transaction");

endmodule

bind phasor_frame_serializer pfs_checker u_pfs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last_byte (last_byte)
);
`default_nettype wire
